// ===== hw/rtl/pfv_pkg.sv =====
// Shared types, register map and CRC helper for the packet frame validator.
package pfv_pkg;

  typedef enum logic [1:0] {
    STATUS_VALID  = 2'd0,
    STATUS_SCHEMA = 2'd1,
    STATUS_LENGTH = 2'd2,
    STATUS_CRC    = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    REG_START_DELIM = 2'd0,
    REG_END_DELIM   = 2'd1,
    REG_CRC_POLY    = 2'd2,
    REG_MIN_LENGTH  = 2'd3
  } reg_idx_e;

  localparam int unsigned PaddrWidth    = 4;
  localparam logic [15:0] CrcInit       = 16'hFFFF;
  localparam logic [15:0] CrcMsb        = 16'h8000;
  localparam logic [15:0] CountMax      = 16'hFFFF;
  localparam logic [8:0]  FrameOverhead = 9'd6;

  localparam logic [7:0]  StartDelimRst = 8'd2;
  localparam logic [7:0]  EndDelimRst   = 8'd3;
  localparam logic [15:0] CrcPolyRst    = 16'h1021;
  localparam logic [8:0]  MinLengthRst  = 9'd6;

  // One byte through a bitwise MSB-first CRC-16.
  function automatic logic [15:0] crc16_byte(input logic [15:0] crc,
                                             input logic [7:0]  data,
                                             input logic [15:0] poly);
    logic [15:0] c;
    c = crc ^ {data, 8'h00};
    for (int k = 0; k < 8; k++) begin
      if ((c & CrcMsb) != 16'h0000) begin
        c = {c[14:0], 1'b0} ^ poly;
      end else begin
        c = {c[14:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

// ===== hw/rtl/packet_frame_validator_unit.sv =====
// Delimited frame checker with CRC-16 over the payload and an APB register port.
// The status of a buffer passes from its last byte through the input register, then the result
// register. Throughput: one byte per cycle unless a last byte waits on a held result, set by the
// frame state update with its byte-wide CRC step.
// Reset clears the frame state and the pipeline and loads the register defaults
// (start 0x02, end 0x03, polynomial 0x1021, minimum length 6).
module packet_frame_validator_unit (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic [7:0]                     data_byte_i,
  input  logic                           last_byte_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic [1:0]                     status_o,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [pfv_pkg::PaddrWidth-1:0] paddr,
  input  logic [31:0]                    pwdata,
  output logic [31:0]                    prdata,
  output logic                           pready
);
  import pfv_pkg::*;

  typedef enum logic [2:0] {
    PH_START  = 3'd0,
    PH_CMD    = 3'd1,
    PH_LEN    = 3'd2,
    PH_DATA   = 3'd3,
    PH_CRC_HI = 3'd4,
    PH_CRC_LO = 3'd5,
    PH_END    = 3'd6,
    PH_DONE   = 3'd7
  } phase_e;

  // configuration registers
  logic [7:0]  start_delim_q, end_delim_q;
  logic [15:0] crc_poly_q;
  logic [8:0]  min_length_q;
  reg_idx_e    reg_idx;
  logic        cfg_wr;

  assign pready  = 1'b1;
  assign reg_idx = reg_idx_e'(paddr[3:2]);
  assign cfg_wr  = psel & penable & pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_delim_q <= StartDelimRst;
      end_delim_q   <= EndDelimRst;
      crc_poly_q    <= CrcPolyRst;
      min_length_q  <= MinLengthRst;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        REG_START_DELIM: start_delim_q <= pwdata[7:0];
        REG_END_DELIM:   end_delim_q   <= pwdata[7:0];
        REG_CRC_POLY:    crc_poly_q    <= pwdata[15:0];
        REG_MIN_LENGTH:  min_length_q  <= pwdata[8:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_START_DELIM: prdata = {24'h0, start_delim_q};
      REG_END_DELIM:   prdata = {24'h0, end_delim_q};
      REG_CRC_POLY:    prdata = {16'h0, crc_poly_q};
      REG_MIN_LENGTH:  prdata = {23'h0, min_length_q};
      default:         prdata = 32'h0;
    endcase
  end

  // input register
  logic       s1_valid_q;
  logic [7:0] s1_byte_q;
  logic       s1_last_q;
  logic       out_free, proc, s1_load;

  logic      out_valid_q;
  status_e   out_status_q;

  assign out_free   = ~out_valid_q | ~out_stall_i;
  assign proc       = s1_valid_q & (~s1_last_q | out_free);
  assign in_stall_o = s1_valid_q & ~proc;
  assign s1_load    = in_valid_i & ~in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s1_byte_q  <= 8'h00;
      s1_last_q  <= 1'b0;
    end else begin
      if (s1_load) begin
        s1_valid_q <= 1'b1;
        s1_byte_q  <= data_byte_i;
        s1_last_q  <= last_byte_i;
      end else if (proc) begin
        s1_valid_q <= 1'b0;
      end
    end
  end

  // frame state
  phase_e      phase_q, phase_d, tk_phase;
  logic [15:0] count_q, count_d, tk_count;
  logic [7:0]  decl_len_q, decl_len_d, tk_decl_len;
  logic [7:0]  seen_q, seen_d, tk_seen;
  logic [15:0] crc_q, crc_d, tk_crc;
  logic [7:0]  crc_hi_q, crc_hi_d, tk_crc_hi;
  status_e     err_code_q, err_code_d, tk_err_code;
  logic        err_q, err_d, tk_err;
  logic        is_delim;
  logic [7:0]  seen_inc;
  logic [15:0] crc_next;
  logic [8:0]  need_len;
  status_e     final_status;

  assign is_delim = (s1_byte_q == start_delim_q) | (s1_byte_q == end_delim_q);
  assign seen_inc = seen_q + 8'd1;
  assign crc_next = crc16_byte(crc_q, s1_byte_q, crc_poly_q);

  // apply one byte to the frame state
  always_comb begin
    tk_phase    = phase_q;
    tk_decl_len = decl_len_q;
    tk_seen     = seen_q;
    tk_crc      = crc_q;
    tk_crc_hi   = crc_hi_q;
    tk_err_code = err_code_q;
    tk_err      = err_q;
    tk_count    = (count_q == CountMax) ? count_q : count_q + 16'd1;
    if (!err_q) begin
      unique case (phase_q)
        PH_START: begin
          if (s1_byte_q != start_delim_q) begin
            tk_err = 1'b1; tk_err_code = STATUS_SCHEMA;
          end else begin
            tk_phase = PH_CMD;
          end
        end
        PH_CMD: begin
          if (is_delim) begin
            tk_err = 1'b1; tk_err_code = STATUS_SCHEMA;
          end else begin
            tk_phase = PH_LEN;
          end
        end
        PH_LEN: begin
          tk_decl_len = s1_byte_q;
          tk_seen     = 8'd0;
          tk_phase    = (s1_byte_q == 8'd0) ? PH_CRC_HI : PH_DATA;
        end
        PH_DATA: begin
          if (is_delim) begin
            tk_err = 1'b1; tk_err_code = STATUS_LENGTH;
          end else begin
            tk_crc  = crc_next;
            tk_seen = seen_inc;
            if (seen_inc >= decl_len_q) tk_phase = PH_CRC_HI;
          end
        end
        PH_CRC_HI: begin
          tk_crc_hi = s1_byte_q;
          tk_phase  = PH_CRC_LO;
        end
        PH_CRC_LO: begin
          if ({crc_hi_q, s1_byte_q} != crc_q) begin
            tk_err = 1'b1; tk_err_code = STATUS_CRC;
          end else begin
            tk_phase = PH_END;
          end
        end
        PH_END: begin
          if (s1_byte_q != end_delim_q) begin
            tk_err = 1'b1; tk_err_code = STATUS_SCHEMA;
          end else begin
            tk_phase = PH_DONE;
          end
        end
        PH_DONE: ;
        default: ;
      endcase
    end
  end

  assign need_len = {1'b0, tk_decl_len} + FrameOverhead;

  // short buffer outranks all; header errors precede the length check
  always_comb begin
    priority if (tk_count < {7'h0, min_length_q}) begin
      final_status = STATUS_SCHEMA;
    end else if (tk_err && (tk_phase < PH_LEN)) begin
      final_status = tk_err_code;
    end else if (tk_phase < PH_DATA) begin
      final_status = STATUS_SCHEMA;
    end else if ({7'h0, need_len} > tk_count) begin
      final_status = STATUS_LENGTH;
    end else if (tk_err) begin
      final_status = tk_err_code;
    end else if (tk_phase == PH_DONE) begin
      final_status = STATUS_VALID;
    end else begin
      final_status = STATUS_SCHEMA;
    end
  end

  always_comb begin
    phase_d    = phase_q;
    count_d    = count_q;
    decl_len_d = decl_len_q;
    seen_d     = seen_q;
    crc_d      = crc_q;
    crc_hi_d   = crc_hi_q;
    err_code_d = err_code_q;
    err_d      = err_q;
    if (proc) begin
      if (s1_last_q) begin
        // clear for the next buffer
        phase_d    = PH_START;
        count_d    = 16'd0;
        decl_len_d = 8'd0;
        seen_d     = 8'd0;
        crc_d      = CrcInit;
        crc_hi_d   = 8'd0;
        err_code_d = STATUS_VALID;
        err_d      = 1'b0;
      end else begin
        phase_d    = tk_phase;
        count_d    = tk_count;
        decl_len_d = tk_decl_len;
        seen_d     = tk_seen;
        crc_d      = tk_crc;
        crc_hi_d   = tk_crc_hi;
        err_code_d = tk_err_code;
        err_d      = tk_err;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= PH_START;
      count_q    <= 16'd0;
      decl_len_q <= 8'd0;
      seen_q     <= 8'd0;
      crc_q      <= CrcInit;
      crc_hi_q   <= 8'd0;
      err_code_q <= STATUS_VALID;
      err_q      <= 1'b0;
    end else begin
      phase_q    <= phase_d;
      count_q    <= count_d;
      decl_len_q <= decl_len_d;
      seen_q     <= seen_d;
      crc_q      <= crc_d;
      crc_hi_q   <= crc_hi_d;
      err_code_q <= err_code_d;
      err_q      <= err_d;
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      out_status_q <= STATUS_VALID;
    end else begin
      if (proc && s1_last_q) begin
        out_valid_q  <= 1'b1;
        out_status_q <= final_status;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign status_o    = out_status_q;

  a_last_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    proc && s1_last_q |=> out_valid_q && (phase_q == PH_START) && !err_q && (count_q == 16'd0))
    else $error("frame state not cleared after last byte");

  a_zero_count_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q == 16'd0) |-> (phase_q == PH_START) && !err_q)
    else $error("frame state advanced without a counted byte");

  a_stall_only_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> s1_valid_q && s1_last_q && out_valid_q)
    else $error("input stalled without a pending result");

  a_no_lost_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_stall_i |-> !proc || !s1_last_q)
    else $error("result overwritten while held");

endmodule
